// File: rtl/core/strs_pkg.sv
// ----------------------------------------------------------------------------
// strs_pkg
// Shared types and constants of the segment tree range sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package strs_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CountW     = 9;
  localparam int unsigned LeafAw     = 8;
  localparam int unsigned MaxLeaves  = 256;
  localparam int unsigned NodeDepth  = 4 * MaxLeaves;
  localparam int unsigned NodeAw     = $clog2(NodeDepth);
  localparam int unsigned StackDepth = 8;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned PaddrW     = 3;

  // Register word indexes on the configuration port
  localparam logic RegLeafCount = 1'b0;

  // Item codes
  localparam logic OpUpdate = 1'b0;
  localparam logic OpQuery  = 1'b1;

  localparam logic [CountW-1:0] LeafCountReset = CountW'(MaxLeaves);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLeaf,
    StPath,
    StQuery,
    StDrain,
    StDone
  } strs_state_e;

  typedef struct packed {
    logic              opcode;
    logic [LeafAw-1:0] position;
    logic [DataW-1:0]  new_value;
    logic [LeafAw-1:0] query_low;
    logic [LeafAw-1:0] query_high;
  } strs_item_t;

  // One pending subtree of a range walk
  typedef struct packed {
    logic [NodeAw-1:0] node;
    logic [LeafAw-1:0] lo;
    logic [LeafAw-1:0] hi;
  } strs_span_t;

endpackage

`default_nettype wire

// File: rtl/core/strs_ram.sv
// ----------------------------------------------------------------------------
// strs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/strs_cfg.sv
// ----------------------------------------------------------------------------
// strs_cfg
// APB register file holding leaf_count; gives the index of the last leaf.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [strs_pkg::PaddrW-1:0]  paddr,
  input  wire logic [strs_pkg::DataW-1:0]   pwdata,
  output logic      [strs_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  output logic      [strs_pkg::LeafAw-1:0]  last_leaf_o
);

  logic [strs_pkg::CountW-1:0] leaf_count_q;
  logic [strs_pkg::CountW-1:0] leaf_count_d;
  logic                        sel_count;

  assign pready    = 1'b1;
  assign sel_count = (paddr[2] == strs_pkg::RegLeafCount);

  always_comb begin
    leaf_count_d = leaf_count_q;
    if (psel && penable && pwrite && sel_count) begin
      leaf_count_d = pwdata[strs_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= strs_pkg::LeafCountReset;
    end else begin
      leaf_count_q <= leaf_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_count) begin
      prdata = {{(strs_pkg::DataW - strs_pkg::CountW){1'b0}}, leaf_count_q};
    end
  end

  // Clamp the count to one..MaxLeaves, then take one off
  always_comb begin
    priority if (leaf_count_q == '0) begin
      last_leaf_o = '0;
    end else if (leaf_count_q > strs_pkg::CountW'(strs_pkg::MaxLeaves)) begin
      last_leaf_o = strs_pkg::LeafAw'(strs_pkg::MaxLeaves - 1);
    end else begin
      last_leaf_o = strs_pkg::LeafAw'(leaf_count_q - strs_pkg::CountW'(1));
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/strs_walk.sv
// ----------------------------------------------------------------------------
// strs_walk
// Sequencer over the leaf and node RAMs: clearing pass, update path walk,
// range walk with a small subtree stack, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_walk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [strs_pkg::LeafAw-1:0]   last_leaf_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire strs_pkg::strs_item_t          item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [strs_pkg::DataW-1:0]    range_sum_o,
  // leaf RAM
  output logic                               leaf_we_o,
  output logic      [strs_pkg::LeafAw-1:0]   leaf_waddr_o,
  output logic      [strs_pkg::DataW-1:0]    leaf_wdata_o,
  output logic                               leaf_re_o,
  output logic      [strs_pkg::LeafAw-1:0]   leaf_raddr_o,
  input  wire logic [strs_pkg::DataW-1:0]    leaf_rdata_i,
  // node RAM
  output logic                               node_we_o,
  output logic      [strs_pkg::NodeAw-1:0]   node_waddr_o,
  output logic      [strs_pkg::DataW-1:0]    node_wdata_o,
  output logic                               node_re_o,
  output logic      [strs_pkg::NodeAw-1:0]   node_raddr_o,
  input  wire logic [strs_pkg::DataW-1:0]    node_rdata_i
);

  strs_pkg::strs_state_e state_q, state_d;

  logic [strs_pkg::NodeAw-1:0] clr_q, clr_d;
  logic [strs_pkg::LeafAw-1:0] pos_q, pos_d;
  logic [strs_pkg::DataW-1:0]  val_q, val_d;
  logic [strs_pkg::LeafAw-1:0] qlo_q, qlo_d;
  logic [strs_pkg::LeafAw-1:0] qhi_q, qhi_d;
  logic [strs_pkg::DataW-1:0]  delta_q, delta_d;
  logic [strs_pkg::DataW-1:0]  acc_q, acc_d;
  logic                        acc_pend_q, acc_pend_d;
  strs_pkg::strs_span_t        cur_q, cur_d;
  strs_pkg::strs_span_t        stack_q [strs_pkg::StackDepth];
  logic [strs_pkg::StackAw:0]  sp_q, sp_d;
  logic                        push;
  logic                        out_valid_q, out_valid_d;
  logic [strs_pkg::DataW-1:0]  out_sum_q, out_sum_d;

  logic [strs_pkg::LeafAw:0]   mid_sum;
  logic [strs_pkg::LeafAw-1:0] mid;
  logic [strs_pkg::NodeAw-1:0] left_node;
  logic [strs_pkg::NodeAw-1:0] right_node;
  logic                        covered;
  logic                        disjoint;
  logic [strs_pkg::LeafAw-1:0] lo_clip;
  logic [strs_pkg::LeafAw-1:0] hi_clip;
  logic                        out_free;
  strs_pkg::strs_span_t        top_span;
  strs_pkg::strs_span_t        right_span;
  logic [strs_pkg::StackAw:0]  sp_dec;

  assign mid_sum    = {1'b0, cur_q.lo} + {1'b0, cur_q.hi};
  assign mid        = mid_sum[strs_pkg::LeafAw:1];
  assign left_node  = {cur_q.node[strs_pkg::NodeAw-2:0], 1'b1};
  assign right_node = {cur_q.node[strs_pkg::NodeAw-2:0], 1'b0}
                      + strs_pkg::NodeAw'(2);
  assign covered    = (qlo_q <= cur_q.lo) && (qhi_q >= cur_q.hi);
  assign disjoint   = (cur_q.hi < qlo_q) || (cur_q.lo > qhi_q);
  assign lo_clip    = (item_i.query_low  > last_leaf_i) ? last_leaf_i : item_i.query_low;
  assign hi_clip    = (item_i.query_high > last_leaf_i) ? last_leaf_i : item_i.query_high;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sp_dec     = sp_q - (strs_pkg::StackAw + 1)'(1);
  assign top_span   = stack_q[sp_dec[strs_pkg::StackAw-1:0]];
  assign right_span = '{node: right_node, lo: mid + strs_pkg::LeafAw'(1), hi: cur_q.hi};

  assign in_stall_o  = (state_q != strs_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    qlo_d       = qlo_q;
    qhi_d       = qhi_q;
    delta_d     = delta_q;
    acc_d       = acc_q;
    acc_pend_d  = 1'b0;
    cur_d       = cur_q;
    sp_d        = sp_q;
    push        = 1'b0;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;

    leaf_we_o    = 1'b0;
    leaf_waddr_o = pos_q;
    leaf_wdata_o = val_q;
    leaf_re_o    = 1'b0;
    leaf_raddr_o = item_i.position;
    node_we_o    = 1'b0;
    node_waddr_o = cur_q.node;
    node_wdata_o = node_rdata_i + delta_q;
    node_re_o    = 1'b0;
    node_raddr_o = cur_q.node;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    // fold in the node read issued last cycle
    if (acc_pend_q) begin
      acc_d = acc_q + node_rdata_i;
    end

    unique case (state_q)
      strs_pkg::StClear: begin
        leaf_we_o    = 1'b1;
        leaf_waddr_o = clr_q[strs_pkg::LeafAw-1:0];
        leaf_wdata_o = '0;
        node_we_o    = 1'b1;
        node_waddr_o = clr_q;
        node_wdata_o = '0;
        clr_d        = clr_q + strs_pkg::NodeAw'(1);
        if (clr_q == '1) begin
          state_d = strs_pkg::StIdle;
        end
      end

      strs_pkg::StIdle: begin
        if (in_valid_i) begin
          pos_d = item_i.position;
          val_d = item_i.new_value;
          qlo_d = lo_clip;
          qhi_d = hi_clip;
          cur_d = '{node: '0, lo: '0, hi: last_leaf_i};
          sp_d  = '0;
          acc_d = '0;
          if (item_i.opcode == strs_pkg::OpQuery) begin
            state_d = (lo_clip > hi_clip) ? strs_pkg::StDone : strs_pkg::StQuery;
          end else if (item_i.position <= last_leaf_i) begin
            leaf_re_o = 1'b1;
            state_d   = strs_pkg::StLeaf;
          end
          // drop updates beyond the tree
        end
      end

      strs_pkg::StLeaf: begin
        delta_d   = val_q - leaf_rdata_i;
        leaf_we_o = 1'b1;
        node_re_o = 1'b1;
        state_d   = strs_pkg::StPath;
      end

      strs_pkg::StPath: begin
        node_we_o = 1'b1;
        if (cur_q.lo == cur_q.hi) begin
          state_d = strs_pkg::StIdle;
        end else begin
          if (pos_q <= mid) begin
            cur_d = '{node: left_node, lo: cur_q.lo, hi: mid};
          end else begin
            cur_d = right_span;
          end
          node_re_o    = 1'b1;
          node_raddr_o = cur_d.node;
        end
      end

      strs_pkg::StQuery: begin
        if (covered || disjoint) begin
          if (covered) begin
            node_re_o  = 1'b1;
            acc_pend_d = 1'b1;
          end
          if (sp_q == '0) begin
            state_d = strs_pkg::StDrain;
          end else begin
            cur_d = top_span;
            sp_d  = sp_dec;
          end
        end else begin
          push  = 1'b1;
          sp_d  = sp_q + (strs_pkg::StackAw + 1)'(1);
          cur_d = '{node: left_node, lo: cur_q.lo, hi: mid};
        end
      end

      strs_pkg::StDrain: begin
        state_d = strs_pkg::StDone;
      end

      strs_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          state_d     = strs_pkg::StIdle;
        end
      end

      default: begin
        state_d = strs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= strs_pkg::StClear;
      clr_q       <= '0;
      sp_q        <= '0;
      acc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      acc_pend_q  <= acc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    val_q     <= val_d;
    qlo_q     <= qlo_d;
    qhi_q     <= qhi_d;
    delta_q   <= delta_d;
    acc_q     <= acc_d;
    cur_q     <= cur_d;
    out_sum_q <= out_sum_d;
    if (push) begin
      stack_q[sp_q[strs_pkg::StackAw-1:0]] <= right_span;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/segment_tree_range_sum.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Range sums over 256 signed 32-bit leaves kept as a segment tree in RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// opcode 0 stores new_value at position and adds the difference along the
// leaf's path (no result); opcode 1 returns the wrapping sum of the leaves
// from query_low to query_high, both clipped to leaf_count-1, or zero when
// the range is empty. Results leave on out_valid_o / out_stall_i.
// The block takes one item at a time. An update reads the old leaf, then
// walks the tree depth (up to 9 nodes on a path), one node read-modify-write
// per cycle on the node RAM. A query visits the tree nodes of its range walk
// (at most about four per level), one per cycle on the node RAM read port.
// Updates beyond leaf_count are dropped.
// A result waits in the output register while out_stall_i is high; the next
// item is taken meanwhile, and a later query holds until that register frees.
// After reset a clearing pass zeroes both RAMs, in_stall_o stays high for its
// length; leaf_count resets to 256 and may be written over the APB port at any
// time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [strs_pkg::PaddrW-1:0]  paddr,
  input  wire logic [strs_pkg::DataW-1:0]   pwdata,
  output logic      [strs_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [strs_pkg::LeafAw-1:0]  position_i,
  input  wire logic [strs_pkg::DataW-1:0]   new_value_i,
  input  wire logic [strs_pkg::LeafAw-1:0]  query_low_i,
  input  wire logic [strs_pkg::LeafAw-1:0]  query_high_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [strs_pkg::DataW-1:0]   range_sum_o
);

  logic [strs_pkg::LeafAw-1:0] last_leaf;
  strs_pkg::strs_item_t        item;

  logic                        leaf_we;
  logic [strs_pkg::LeafAw-1:0] leaf_waddr;
  logic [strs_pkg::DataW-1:0]  leaf_wdata;
  logic                        leaf_re;
  logic [strs_pkg::LeafAw-1:0] leaf_raddr;
  logic [strs_pkg::DataW-1:0]  leaf_rdata;
  logic                        node_we;
  logic [strs_pkg::NodeAw-1:0] node_waddr;
  logic [strs_pkg::DataW-1:0]  node_wdata;
  logic                        node_re;
  logic [strs_pkg::NodeAw-1:0] node_raddr;
  logic [strs_pkg::DataW-1:0]  node_rdata;

  assign item = '{
    opcode:     opcode_i,
    position:   position_i,
    new_value:  new_value_i,
    query_low:  query_low_i,
    query_high: query_high_i
  };

  strs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .last_leaf_o (last_leaf)
  );

  strs_ram #(
    .Width (strs_pkg::DataW),
    .Depth (strs_pkg::MaxLeaves)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (leaf_we),
    .waddr_i (leaf_waddr),
    .wdata_i (leaf_wdata),
    .re_i    (leaf_re),
    .raddr_i (leaf_raddr),
    .rdata_o (leaf_rdata)
  );

  strs_ram #(
    .Width (strs_pkg::DataW),
    .Depth (strs_pkg::NodeDepth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  strs_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .last_leaf_i  (last_leaf),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .range_sum_o  (range_sum_o),
    .leaf_we_o    (leaf_we),
    .leaf_waddr_o (leaf_waddr),
    .leaf_wdata_o (leaf_wdata),
    .leaf_re_o    (leaf_re),
    .leaf_raddr_o (leaf_raddr),
    .leaf_rdata_i (leaf_rdata),
    .node_we_o    (node_we),
    .node_waddr_o (node_waddr),
    .node_wdata_o (node_wdata),
    .node_re_o    (node_re),
    .node_raddr_o (node_raddr),
    .node_rdata_i (node_rdata)
  );

endmodule

`default_nettype wire
